/* src/htap_pkg.sv */
package htap_pkg;

  localparam int QW      = 16;             // quaternion component
  localparam int TIME_W  = 32;
  localparam int ACC_W   = 35;             // sums of quaternion products
  localparam int S_W     = 30;             // clamped asin argument, +-2^28
  localparam int SQ_W    = 57;             // square root radicand
  localparam int PROD_W  = 58;             // shared multiplier result kept
  localparam int CW_W    = 45;             // cordic x/y word
  localparam int Z_W     = 34;             // cordic binary angle
  localparam int UNIT_W  = 52;             // angle scaling product
  localparam int ANG_W   = 36;             // angle in Q16.16 units
  localparam int CTR_W   = 40;             // centers, Q16.16
  localparam int DCL_W   = 31;             // clamped centered angle
  localparam int AXP_W   = 40;             // centered angle times gain
  localparam int AX_W    = 16;             // output axis
  localparam int DIV_W   = 14;             // divider divisor
  localparam int GAIN_W  = 8;
  localparam int CNT_W   = 8;

  localparam int CORDIC_STEPS = 24;
  localparam int NORM_BIT     = 40;

  localparam logic signed [Z_W-1:0]   HALF_TURN = 34'sd2147483648;
  localparam logic signed [S_W-1:0]   S_LIM     = 30'sd268435456;
  localparam logic [SQ_W-1:0]         SQ_ONE    = 57'd72057594037927936;
  localparam logic signed [CTR_W:0]   CLAMP_IN  = 41'sd1073676288;
  localparam logic signed [CTR_W:0]   CTR_MAX   = 41'sd549755813887;
  localparam logic signed [CTR_W:0]   CTR_MIN   = -41'sd549755813888;
  localparam logic signed [AXP_W-1:0] TRUNC_ADD = 40'sd1048575;
  localparam int                      AXP_SHIFT = 20;
  localparam logic signed [AXP_W-1:0] AX_MAX    = 40'sd32767;
  localparam logic signed [AX_W-1:0]  AX_MAX16  = 16'sd32767;

  localparam logic signed [AX_W-1:0]  AUTO_YAW_LIM   = 16'sd3000;
  localparam logic signed [AX_W:0]    AUTO_STEP_LIM  = 17'sd5;
  localparam logic signed [AX_W-1:0]  AUTO_PITCH_LIM = 16'sd600;
  localparam logic [TIME_W-1:0]       DRIFT_PERIOD   = 32'd1000;
  localparam logic [DIV_W-1:0]        DRIFT_DIV      = 14'd10000;
  localparam logic [CNT_W-1:0]        CALIB_DEFAULT  = 8'd200;

  // register indexes
  localparam logic [2:0] REG_YAW_GAIN    = 3'd0;
  localparam logic [2:0] REG_PITCH_GAIN  = 3'd1;
  localparam logic [2:0] REG_ROLL_GAIN   = 3'd2;
  localparam logic [2:0] REG_SETTLE      = 3'd3;
  localparam logic [2:0] REG_CALIB_SAMP  = 3'd4;
  localparam logic [2:0] REG_DRIFT       = 3'd5;
  localparam logic [2:0] REG_AUTO_EN     = 3'd6;

  // arctangent of 2^-i in binary angle units, 2^32 per turn
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10680862;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [CTR_W-1:0] sat_center(input logic signed [CTR_W:0] v);
    logic signed [CTR_W:0] r;
    if (v > CTR_MAX) begin
      r = CTR_MAX;
    end else if (v < CTR_MIN) begin
      r = CTR_MIN;
    end else begin
      r = v;
    end
    return r[CTR_W-1:0];
  endfunction

endpackage

/* src/htap_cordic.sv */
module htap_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [htap_pkg::ACC_W-1:0] y_in,
  input  logic signed [htap_pkg::ACC_W-1:0] x_in,
  output logic                              done,
  output logic signed [htap_pkg::Z_W-1:0]   z_out
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ROT  = 2'd2;
  localparam logic signed [htap_pkg::CW_W-1:0] NORM_LIM =
    htap_pkg::CW_W'(1) <<< htap_pkg::NORM_BIT;
  localparam logic [4:0] LAST_STEP = 5'(htap_pkg::CORDIC_STEPS - 1);

  logic [1:0]                         state;
  logic signed [htap_pkg::CW_W-1:0]   x, y;
  logic signed [htap_pkg::Z_W-1:0]    z;
  logic [4:0]                         step;

  logic signed [htap_pkg::CW_W-1:0]   xe, ye, xs, ys, x_next, y_next;
  logic signed [htap_pkg::Z_W-1:0]    tab, z_next;
  logic                               big;

  assign xe  = htap_pkg::CW_W'(x_in);
  assign ye  = htap_pkg::CW_W'(y_in);
  assign xs  = x >>> step;
  assign ys  = y >>> step;
  assign tab = $signed({4'b0, htap_pkg::atan_entry(step)});
  assign big = (x >= NORM_LIM) || (y >= NORM_LIM) || (y <= -NORM_LIM);

  always_comb begin
    if (!y[htap_pkg::CW_W-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + tab;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - tab;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            if (xe == '0 && ye == '0) begin
              z_out <= '0;
              done  <= 1'b1;
            end else begin
              state <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (big) begin
            state <= C_ROT;
          end
        end
        C_ROT: begin
          if (step == LAST_STEP) begin
            z_out <= z_next;
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        step <= '0;
        // left half plane: turn by half a circle first
        if (xe < 0) begin
          x <= -xe;
          y <= -ye;
          z <= (ye >= 0) ? htap_pkg::HALF_TURN : -htap_pkg::HALF_TURN;
        end else begin
          x <= xe;
          y <= ye;
          z <= '0;
        end
      end
      C_NORM: begin
        if (!big) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      C_ROT: begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        step <= step + 5'd1;
      end
      default: step <= '0;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) start |-> state == C_IDLE)
    else $error("cordic started while busy");
  assert property (@(posedge clk) disable iff (rst) state == C_ROT |-> x >= 0)
    else $error("cordic x went negative");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("cordic done held longer than one cycle");

endmodule

/* src/htap_div.sv */
module htap_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [htap_pkg::CTR_W-1:0] dividend,
  input  logic [htap_pkg::DIV_W-1:0]        divisor,
  output logic                              done,
  output logic signed [htap_pkg::CTR_W-1:0] quotient
);

  localparam int CNT_W = $clog2(htap_pkg::CTR_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(htap_pkg::CTR_W - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [htap_pkg::CTR_W-1:0]    mag;   // dividend bits out, quotient bits in
  logic [htap_pkg::DIV_W:0]      rem;
  logic [htap_pkg::DIV_W-1:0]    dvs;
  logic                          neg;

  logic [htap_pkg::DIV_W:0]      rem_sh, rem_sub;
  logic                          fits;

  assign rem_sh  = {rem[htap_pkg::DIV_W-1:0], mag[htap_pkg::CTR_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fits    = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        busy <= start;
      end else if (cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      cnt <= '0;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[htap_pkg::CTR_W-1];
      mag <= dividend[htap_pkg::CTR_W-1] ? -dividend : dividend;
    end else begin
      cnt <= cnt + 1'b1;
      rem <= fits ? rem_sub : rem_sh;
      mag <= {mag[htap_pkg::CTR_W-2:0], fits};
    end
  end

  // truncation toward zero: divide magnitudes, restore the sign
  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule

/* src/head_tracker_angle_processor.sv */
// an accepted item runs through the word-serial cordic three times (up to 40 normalizing
// shifts plus 24 rotations each), a bit-serial square root and serial divisions (40 steps)
// flow: one item at a time; the next item is taken once the previous one has finished, and
// items still settling are taken and dropped while idle
// rst (synchronous) clears centers, calibration and drift state and loads register defaults
module head_tracker_angle_processor #(
  parameter int ZONE_COUNT = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z, time_ms, recenter_request
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,   // yaw_axis, pitch_axis, roll_axis
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int ZT_W = $clog2(ZONE_COUNT + 1);
  localparam logic [ZT_W-1:0] ZONE_LAST = ZT_W'(ZONE_COUNT);
  localparam logic [htap_pkg::DIV_W-1:0] ZONE_DIV = htap_pkg::DIV_W'(10 * ZONE_COUNT);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_MUL       = 5'd1;
  localparam logic [4:0] S_CLAMP     = 5'd2;
  localparam logic [4:0] S_SQ        = 5'd3;
  localparam logic [4:0] S_SQRT_INIT = 5'd4;
  localparam logic [4:0] S_SQRT      = 5'd5;
  localparam logic [4:0] S_CSTART    = 5'd6;
  localparam logic [4:0] S_CWAIT     = 5'd7;
  localparam logic [4:0] S_UPD       = 5'd8;
  localparam logic [4:0] S_DIV_START = 5'd9;
  localparam logic [4:0] S_DIV_WAIT  = 5'd10;
  localparam logic [4:0] S_AX_D      = 5'd11;
  localparam logic [4:0] S_AX_M      = 5'd12;
  localparam logic [4:0] S_AX_S      = 5'd13;
  localparam logic [4:0] S_AUTO      = 5'd14;
  localparam logic [4:0] S_DRIFT     = 5'd15;
  localparam logic [4:0] S_OUT       = 5'd16;

  localparam logic [2:0] TAG_CAL_YAW   = 3'd0;
  localparam logic [2:0] TAG_CAL_PITCH = 3'd1;
  localparam logic [2:0] TAG_CAL_ROLL  = 3'd2;
  localparam logic [2:0] TAG_AUTO      = 3'd3;
  localparam logic [2:0] TAG_DRIFT     = 3'd4;

  localparam logic [1:0] AXIS_YAW   = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_ROLL  = 2'd2;

  // configuration
  logic [htap_pkg::GAIN_W-1:0]       yaw_gain, pitch_gain, roll_gain;
  logic [15:0]                       settle_time_ms;
  logic [htap_pkg::CNT_W-1:0]        calibration_samples;
  logic signed [15:0]                drift_comp;
  logic                              auto_center_enable;
  logic                              cfg_wr;

  // tracking state
  logic [4:0]                        state;
  logic signed [htap_pkg::CTR_W-1:0] yaw_center, pitch_center, roll_center;
  logic [htap_pkg::CNT_W-1:0]        calib_count;
  logic                              is_calibrated;
  logic [ZT_W-1:0]                   zone_ticks;
  logic signed [23:0]                zone_yaw_sum;
  logic signed [htap_pkg::AX_W-1:0]  prev_yaw_out;
  logic [htap_pkg::TIME_W-1:0]       next_drift_time;
  logic [3:0]                        k;
  logic [1:0]                        sel;
  logic [2:0]                        tag;

  // item payload and working registers
  logic signed [htap_pkg::QW-1:0]    qw, qx, qy, qz;
  logic [htap_pkg::TIME_W-1:0]       t_ms;
  logic                              btn;
  logic signed [htap_pkg::ACC_W-1:0] acc_rx, acc_ry, acc_yx, acc_yy, acc_s;
  logic signed [htap_pkg::S_W-1:0]   s_cl;
  logic [htap_pkg::SQ_W-1:0]         sq_v, sq_r, sq_bit;
  logic signed [htap_pkg::PROD_W-1:0] prod_r;
  logic signed [htap_pkg::ANG_W-1:0] yaw_ang, pitch_ang, roll_ang;
  logic signed [htap_pkg::DCL_W-1:0] d_cl;
  logic signed [htap_pkg::AX_W-1:0]  yaw_out, pitch_out, roll_out;
  logic signed [23:0]                auto_num;

  // combinational
  logic signed [31:0]                mul_a, mul_b;
  logic signed [63:0]                mul_p;
  logic signed [htap_pkg::ACC_W-1:0] p_acc;
  logic signed [htap_pkg::ACC_W:0]   s2;
  logic [htap_pkg::SQ_W-1:0]         sq_t;
  logic                              c_start, c_done;
  logic signed [htap_pkg::ACC_W-1:0] c_y, c_x;
  logic signed [htap_pkg::Z_W-1:0]   c_z;
  logic signed [htap_pkg::Z_W:0]     z_sgn;
  logic signed [htap_pkg::UNIT_W-1:0] z_wide, z_unit;
  logic signed [htap_pkg::ANG_W-1:0] ang_new;
  logic                              d_start, d_done;
  logic signed [htap_pkg::CTR_W-1:0] d_num, d_quo;
  logic [htap_pkg::DIV_W-1:0]        d_den;
  logic signed [htap_pkg::ANG_W-1:0] ang_sel;
  logic signed [htap_pkg::CTR_W-1:0] ctr_sel;
  logic [htap_pkg::GAIN_W-1:0]       gain_sel;
  logic signed [htap_pkg::CTR_W:0]   dd;
  logic signed [htap_pkg::AXP_W-1:0] ap, ap_b, aq;
  logic signed [htap_pkg::AX_W-1:0]  ax_val;
  logic signed [htap_pkg::AX_W:0]    dy;
  logic                              in_zone;
  logic [ZT_W-1:0]                   ticks_new;
  logic signed [23:0]                sum_new;
  logic signed [htap_pkg::CTR_W:0]   yaw_add_q;

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      htap_pkg::REG_YAW_GAIN:   prdata = {24'd0, yaw_gain};
      htap_pkg::REG_PITCH_GAIN: prdata = {24'd0, pitch_gain};
      htap_pkg::REG_ROLL_GAIN:  prdata = {24'd0, roll_gain};
      htap_pkg::REG_SETTLE:     prdata = {16'd0, settle_time_ms};
      htap_pkg::REG_CALIB_SAMP: prdata = {24'd0, calibration_samples};
      htap_pkg::REG_DRIFT:      prdata = {16'd0, drift_comp};
      htap_pkg::REG_AUTO_EN:    prdata = {31'd0, auto_center_enable};
      default:                  prdata = '0;
    endcase
  end

  // shared multiplier: quaternion products, asin argument square, axis gain
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        case (k)
          4'd0: begin mul_a = 32'(qw); mul_b = 32'(qw); end
          4'd1: begin mul_a = 32'(qx); mul_b = 32'(qx); end
          4'd2: begin mul_a = 32'(qy); mul_b = 32'(qy); end
          4'd3: begin mul_a = 32'(qz); mul_b = 32'(qz); end
          4'd4: begin mul_a = 32'(qy); mul_b = 32'(qz); end
          4'd5: begin mul_a = 32'(qw); mul_b = 32'(qx); end
          4'd6: begin mul_a = 32'(qx); mul_b = 32'(qy); end
          4'd7: begin mul_a = 32'(qw); mul_b = 32'(qz); end
          4'd8: begin mul_a = 32'(qx); mul_b = 32'(qz); end
          4'd9: begin mul_a = 32'(qw); mul_b = 32'(qy); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SQ: begin
        mul_a = 32'(s_cl);
        mul_b = 32'(s_cl);
      end
      S_AX_M: begin
        mul_a = 32'(d_cl);
        mul_b = $signed({24'd0, gain_sel});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign p_acc = prod_r[htap_pkg::ACC_W-1:0];
  assign s2    = {acc_s, 1'b0};
  assign sq_t  = sq_r + sq_bit;

  // cordic operands: roll, then pitch, then yaw
  always_comb begin
    case (sel)
      AXIS_ROLL: begin
        c_y = acc_ry <<< 1;
        c_x = acc_rx;
      end
      AXIS_PITCH: begin
        c_y = htap_pkg::ACC_W'(s_cl);
        c_x = $signed({{(htap_pkg::ACC_W-29){1'b0}}, sq_r[28:0]});
      end
      default: begin
        c_y = acc_yy <<< 1;
        c_x = acc_yx;
      end
    endcase
  end

  assign c_start = (state == S_CSTART);

  htap_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .done  (c_done),
    .z_out (c_z)
  );

  // binary angle to Q16.16 angle units: floor(z * 65534 / 2^16), yaw mirrored
  assign z_sgn   = (sel == AXIS_YAW) ? -(htap_pkg::Z_W + 1)'(c_z) : (htap_pkg::Z_W + 1)'(c_z);
  assign z_wide  = htap_pkg::UNIT_W'(z_sgn);
  assign z_unit  = ((z_wide <<< 16) - (z_wide <<< 1)) >>> 16;
  assign ang_new = z_unit[htap_pkg::ANG_W-1:0];

  // divider operands
  always_comb begin
    case (tag)
      TAG_CAL_YAW: begin
        d_num = yaw_center;
        d_den = htap_pkg::DIV_W'(calib_count);
      end
      TAG_CAL_PITCH: begin
        d_num = pitch_center;
        d_den = htap_pkg::DIV_W'(calib_count);
      end
      TAG_CAL_ROLL: begin
        d_num = roll_center;
        d_den = htap_pkg::DIV_W'(calib_count);
      end
      TAG_AUTO: begin
        d_num = $signed({auto_num, 16'd0});
        d_den = ZONE_DIV;
      end
      default: begin
        d_num = $signed({{8{drift_comp[15]}}, drift_comp, 16'd0});
        d_den = htap_pkg::DRIFT_DIV;
      end
    endcase
  end

  assign d_start = (state == S_DIV_START);

  htap_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (d_start),
    .dividend (d_num),
    .divisor  (d_den),
    .done     (d_done),
    .quotient (d_quo)
  );

  assign yaw_add_q = (htap_pkg::CTR_W + 1)'(yaw_center) + (htap_pkg::CTR_W + 1)'(d_quo);

  // per-axis selection
  always_comb begin
    case (sel)
      AXIS_YAW: begin
        ang_sel  = yaw_ang;
        ctr_sel  = yaw_center;
        gain_sel = yaw_gain;
      end
      AXIS_PITCH: begin
        ang_sel  = pitch_ang;
        ctr_sel  = pitch_center;
        gain_sel = pitch_gain;
      end
      default: begin
        ang_sel  = roll_ang;
        ctr_sel  = roll_center;
        gain_sel = roll_gain;
      end
    endcase
  end

  assign dd   = (htap_pkg::CTR_W + 1)'(ang_sel) - (htap_pkg::CTR_W + 1)'(ctr_sel);
  assign ap   = prod_r[htap_pkg::AXP_W-1:0];
  // divide by 2^20 truncating toward zero
  assign ap_b = ap[htap_pkg::AXP_W-1] ? ap + htap_pkg::TRUNC_ADD : ap;
  assign aq   = ap_b >>> htap_pkg::AXP_SHIFT;

  always_comb begin
    if (aq > htap_pkg::AX_MAX) begin
      ax_val = htap_pkg::AX_MAX16;
    end else if (aq < -htap_pkg::AX_MAX) begin
      ax_val = -htap_pkg::AX_MAX16;
    end else begin
      ax_val = aq[htap_pkg::AX_W-1:0];
    end
  end

  // auto recentering zone: looking ahead and holding still
  assign dy = (htap_pkg::AX_W + 1)'(yaw_out) - (htap_pkg::AX_W + 1)'(prev_yaw_out);
  assign in_zone = (yaw_out > -htap_pkg::AUTO_YAW_LIM) && (yaw_out < htap_pkg::AUTO_YAW_LIM) &&
                   (dy > -htap_pkg::AUTO_STEP_LIM) && (dy < htap_pkg::AUTO_STEP_LIM) &&
                   (pitch_out > -htap_pkg::AUTO_PITCH_LIM) &&
                   (pitch_out < htap_pkg::AUTO_PITCH_LIM);
  assign ticks_new = in_zone ? zone_ticks + 1'b1 : '0;
  assign sum_new   = in_zone ? zone_yaw_sum + 24'(yaw_out) : '0;

  // control and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      yaw_gain            <= 8'd64;
      pitch_gain          <= 8'd64;
      roll_gain           <= 8'd64;
      settle_time_ms      <= 16'd10000;
      calibration_samples <= htap_pkg::CALIB_DEFAULT;
      drift_comp          <= '0;
      auto_center_enable  <= 1'b1;
      yaw_center          <= '0;
      pitch_center        <= '0;
      roll_center         <= '0;
      calib_count         <= '0;
      is_calibrated       <= 1'b0;
      zone_ticks          <= '0;
      zone_yaw_sum        <= '0;
      prev_yaw_out        <= '0;
      next_drift_time     <= '0;
      m_tvalid            <= 1'b0;
      k                   <= '0;
      sel                 <= '0;
      tag                 <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          htap_pkg::REG_YAW_GAIN:   yaw_gain            <= pwdata[7:0];
          htap_pkg::REG_PITCH_GAIN: pitch_gain          <= pwdata[7:0];
          htap_pkg::REG_ROLL_GAIN:  roll_gain           <= pwdata[7:0];
          htap_pkg::REG_SETTLE:     settle_time_ms      <= pwdata[15:0];
          htap_pkg::REG_CALIB_SAMP: calibration_samples <= pwdata[7:0];
          htap_pkg::REG_DRIFT:      drift_comp          <= $signed(pwdata[15:0]);
          htap_pkg::REG_AUTO_EN:    auto_center_enable  <= pwdata[0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          k <= '0;
          if (s_tvalid && s_tdata[95:64] >= {16'd0, settle_time_ms}) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          k <= k + 4'd1;
          if (k == 4'd10) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP:     state <= S_SQ;
        S_SQ:        state <= S_SQRT_INIT;
        S_SQRT_INIT: state <= S_SQRT;
        S_SQRT: begin
          if (sq_bit[0]) begin
            sel   <= AXIS_ROLL;
            state <= S_CSTART;
          end
        end
        S_CSTART: state <= S_CWAIT;
        S_CWAIT: begin
          if (c_done) begin
            case (sel)
              AXIS_ROLL: begin
                sel   <= AXIS_PITCH;
                state <= S_CSTART;
              end
              AXIS_PITCH: begin
                sel   <= AXIS_YAW;
                state <= S_CSTART;
              end
              default: state <= S_UPD;
            endcase
          end
        end
        S_UPD: begin
          if (!is_calibrated) begin
            if (calib_count < calibration_samples) begin
              yaw_center   <= htap_pkg::sat_center((htap_pkg::CTR_W + 1)'(yaw_center) +
                                                   (htap_pkg::CTR_W + 1)'(yaw_ang));
              pitch_center <= htap_pkg::sat_center((htap_pkg::CTR_W + 1)'(pitch_center) +
                                                   (htap_pkg::CTR_W + 1)'(pitch_ang));
              roll_center  <= htap_pkg::sat_center((htap_pkg::CTR_W + 1)'(roll_center) +
                                                   (htap_pkg::CTR_W + 1)'(roll_ang));
              calib_count  <= calib_count + 1'b1;
              state        <= S_IDLE;
            end else begin
              is_calibrated       <= 1'b1;
              calibration_samples <= htap_pkg::CALIB_DEFAULT;
              tag                 <= TAG_CAL_YAW;
              state               <= (calib_count != '0) ? S_DIV_START : S_IDLE;
            end
          end else if (btn) begin
            calib_count   <= '0;
            is_calibrated <= 1'b0;
            yaw_center    <= '0;
            pitch_center  <= '0;
            roll_center   <= '0;
            state         <= S_IDLE;
          end else begin
            sel   <= AXIS_YAW;
            state <= S_AX_D;
          end
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (d_done) begin
            case (tag)
              TAG_CAL_YAW: begin
                yaw_center <= d_quo;
                tag        <= TAG_CAL_PITCH;
                state      <= S_DIV_START;
              end
              TAG_CAL_PITCH: begin
                pitch_center <= d_quo;
                tag          <= TAG_CAL_ROLL;
                state        <= S_DIV_START;
              end
              TAG_CAL_ROLL: begin
                roll_center <= d_quo;
                state       <= S_IDLE;
              end
              TAG_AUTO: begin
                yaw_center <= htap_pkg::sat_center(yaw_add_q);
                state      <= S_DRIFT;
              end
              default: begin
                yaw_center <= htap_pkg::sat_center(yaw_add_q);
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_AX_D: state <= S_AX_M;
        S_AX_M: state <= S_AX_S;
        S_AX_S: begin
          case (sel)
            AXIS_YAW: begin
              sel   <= AXIS_PITCH;
              state <= S_AX_D;
            end
            AXIS_PITCH: begin
              sel   <= AXIS_ROLL;
              state <= S_AX_D;
            end
            default: state <= S_AUTO;
          endcase
        end
        S_AUTO: begin
          state <= S_DRIFT;
          if (auto_center_enable) begin
            prev_yaw_out <= yaw_out;
            if (ticks_new >= ZONE_LAST) begin
              zone_ticks   <= '0;
              zone_yaw_sum <= '0;
              tag          <= TAG_AUTO;
              state        <= S_DIV_START;
            end else begin
              zone_ticks   <= ticks_new;
              zone_yaw_sum <= sum_new;
            end
          end
        end
        S_DRIFT: begin
          if (t_ms > next_drift_time) begin
            next_drift_time <= t_ms + htap_pkg::DRIFT_PERIOD;
            tag             <= TAG_DRIFT;
            state           <= S_DIV_START;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p[htap_pkg::PROD_W-1:0];
    case (state)
      S_IDLE: begin
        qw     <= $signed(s_tdata[15:0]);
        qx     <= $signed(s_tdata[31:16]);
        qy     <= $signed(s_tdata[47:32]);
        qz     <= $signed(s_tdata[63:48]);
        t_ms   <= s_tdata[95:64];
        btn    <= s_tdata[96];
        acc_rx <= '0;
        acc_ry <= '0;
        acc_yx <= '0;
        acc_yy <= '0;
        acc_s  <= '0;
      end
      S_MUL: begin
        // product of the previous cycle
        case (k)
          4'd1: begin acc_rx <= acc_rx + p_acc; acc_yx <= acc_yx + p_acc; end
          4'd2: begin acc_rx <= acc_rx - p_acc; acc_yx <= acc_yx + p_acc; end
          4'd3: begin acc_rx <= acc_rx - p_acc; acc_yx <= acc_yx - p_acc; end
          4'd4: begin acc_rx <= acc_rx + p_acc; acc_yx <= acc_yx - p_acc; end
          4'd5: acc_ry <= acc_ry + p_acc;
          4'd6: acc_ry <= acc_ry + p_acc;
          4'd7: acc_yy <= acc_yy + p_acc;
          4'd8: acc_yy <= acc_yy + p_acc;
          4'd9: acc_s  <= acc_s + p_acc;
          4'd10: acc_s <= acc_s - p_acc;
          default: ;
        endcase
      end
      S_CLAMP: begin
        if (s2 > (htap_pkg::ACC_W + 1)'(htap_pkg::S_LIM)) begin
          s_cl <= htap_pkg::S_LIM;
        end else if (s2 < -(htap_pkg::ACC_W + 1)'(htap_pkg::S_LIM)) begin
          s_cl <= -htap_pkg::S_LIM;
        end else begin
          s_cl <= s2[htap_pkg::S_W-1:0];
        end
      end
      S_SQRT_INIT: begin
        sq_v   <= htap_pkg::SQ_ONE - prod_r[htap_pkg::SQ_W-1:0];
        sq_r   <= '0;
        sq_bit <= htap_pkg::SQ_ONE;
      end
      S_SQRT: begin
        // one result bit per cycle
        if (sq_v >= sq_t) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_CWAIT: begin
        if (c_done) begin
          case (sel)
            AXIS_ROLL:  roll_ang  <= ang_new;
            AXIS_PITCH: pitch_ang <= ang_new;
            default:    yaw_ang   <= ang_new;
          endcase
        end
      end
      S_AX_D: begin
        if (dd > htap_pkg::CLAMP_IN) begin
          d_cl <= htap_pkg::CLAMP_IN[htap_pkg::DCL_W-1:0];
        end else if (dd < -htap_pkg::CLAMP_IN) begin
          d_cl <= -htap_pkg::CLAMP_IN[htap_pkg::DCL_W-1:0];
        end else begin
          d_cl <= dd[htap_pkg::DCL_W-1:0];
        end
      end
      S_AX_S: begin
        case (sel)
          AXIS_YAW:   yaw_out   <= ax_val;
          AXIS_PITCH: pitch_out <= ax_val;
          default:    roll_out  <= ax_val;
        endcase
      end
      S_AUTO: auto_num <= sum_new;
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {roll_out, pitch_out, yaw_out};
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> !s_tready ||
                   $past(s_tdata[95:64]) < {16'd0, $past(settle_time_ms)})
    else $error("item accepted back to back during processing");
  assert property (@(posedge clk) disable iff (rst)
                   m_tvalid |-> m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000 &&
                   m_tdata[47:32] != 16'h8000)
    else $error("axis value outside saturation range");
  assert property (@(posedge clk) disable iff (rst) zone_ticks < ZONE_LAST)
    else $error("zone counter not reset at threshold");
  assert property (@(posedge clk) disable iff (rst) c_done |-> state == S_CWAIT)
    else $error("cordic result arrived unexpectedly");
  assert property (@(posedge clk) disable iff (rst) d_done |-> state == S_DIV_WAIT)
    else $error("divider result arrived unexpectedly");

endmodule
